// ----- design/utsc_pkg.sv -----
// Shared types, constants and helper functions for the UTF-8 text statistics counter.
package utsc_pkg;

  localparam int COUNT_BITS     = 32;
  localparam int TAB_STOP       = 8;
  localparam int OUT_BITS       = 32;
  localparam int CP_BITS        = 21;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CP_BITS-1:0]    cp_t;

  localparam count_t CNT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_DATA   = 2'd0,
    ACT_END    = 2'd1,
    ACT_TOTALS = 2'd2
  } action_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDE1_LOW  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDE1_HIGH = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDE2_LOW  = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDE2_HIGH = CFG_INDEX_BITS'(3);

  localparam cp_t WIDE1_LOW_RESET  = CP_BITS'(11904);
  localparam cp_t WIDE1_HIGH_RESET = CP_BITS'(42191);
  localparam cp_t WIDE2_LOW_RESET  = CP_BITS'(44032);
  localparam cp_t WIDE2_HIGH_RESET = CP_BITS'(55203);

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] CONT_MIN   = 8'h80;
  localparam logic [7:0] CONT_MAX   = 8'hBF;
  localparam logic [7:0] LEAD2_MIN  = 8'hC0;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_MAX  = 8'hF7;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] line_total;
    logic [OUT_BITS-1:0] word_total;
    logic [OUT_BITS-1:0] char_total;
    logic [OUT_BITS-1:0] byte_total;
    logic [OUT_BITS-1:0] longest_line;
    logic                encoding_error;
    logic                is_grand_total;
  } out_item_t;

  typedef struct packed {
    cp_t range1_low;
    cp_t range1_high;
    cp_t range2_low;
    cp_t range2_high;
  } wide_cfg_t;

  // Running state of the file being scanned
  typedef struct packed {
    count_t     bytes;
    count_t     chars;
    count_t     words;
    count_t     lines;
    count_t     line_width;
    count_t     longest;
    logic       after_space;
    cp_t        partial;
    logic [1:0] expect_cnt;
  } file_state_t;

  function automatic count_t sat_add(count_t a, count_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  function automatic count_t sat_inc(count_t a);
    return sat_add(a, COUNT_BITS'(1));
  endfunction

  function automatic count_t max_count(count_t a, count_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [OUT_BITS-1:0] to_out(count_t a);
    return OUT_BITS'(a);
  endfunction

  function automatic logic is_ws(logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR);
  endfunction

  function automatic file_state_t file_clear();
    file_state_t f;
    f = '0;
    f.after_space = 1'b1;
    return f;
  endfunction

endpackage

// ----- design/utsc_byte_step.sv -----
// Per-byte UTF-8 decode and count update of the running file state.
module utsc_byte_step (
  input  utsc_pkg::file_state_t cur,
  input  logic [7:0]            data_byte,
  input  utsc_pkg::wide_cfg_t   wide_cfg,
  output utsc_pkg::file_state_t nxt,
  output logic                  bad_byte
);

  utsc_pkg::cp_t    cp;
  logic             is_cont;
  logic             wide;
  logic             fresh;
  logic [1:0]       mb_width;
  utsc_pkg::count_t tab_pad;

  assign cp      = {cur.partial[utsc_pkg::CP_BITS-7:0], data_byte[5:0]};
  assign is_cont = (data_byte >= utsc_pkg::CONT_MIN) && (data_byte <= utsc_pkg::CONT_MAX);
  assign wide    = ((cp >= wide_cfg.range1_low) && (cp <= wide_cfg.range1_high)) ||
                   ((cp >= wide_cfg.range2_low) && (cp <= wide_cfg.range2_high));
  assign mb_width = wide ? 2'd2 : 2'd1;

  // columns up to the next tab stop (tab stop is a power of two)
  assign tab_pad = utsc_pkg::COUNT_BITS'(utsc_pkg::TAB_STOP) -
                   (cur.line_width % utsc_pkg::COUNT_BITS'(utsc_pkg::TAB_STOP));

  always_comb begin
    nxt       = cur;
    bad_byte  = 1'b0;
    fresh     = 1'b1;
    nxt.bytes = utsc_pkg::sat_inc(cur.bytes);

    if (cur.expect_cnt != 2'd0) begin
      if (is_cont) begin
        fresh          = 1'b0;
        nxt.partial    = cp;
        nxt.expect_cnt = cur.expect_cnt - 2'd1;
        if (cur.expect_cnt == 2'd1) begin
          nxt.chars       = utsc_pkg::sat_inc(cur.chars);
          nxt.line_width  = utsc_pkg::sat_add(cur.line_width,
                                              utsc_pkg::COUNT_BITS'(mb_width));
          nxt.words       = cur.after_space ? utsc_pkg::sat_inc(cur.words) : cur.words;
          nxt.after_space = 1'b0;
        end
      end else begin
        // broken sequence: drop the partial character, reuse the byte
        bad_byte       = 1'b1;
        nxt.partial    = '0;
        nxt.expect_cnt = 2'd0;
      end
    end

    if (fresh) begin
      if (data_byte <= utsc_pkg::ASCII_MAX) begin
        nxt.chars = utsc_pkg::sat_inc(cur.chars);
        if (data_byte == utsc_pkg::CHAR_LF) begin
          nxt.lines      = utsc_pkg::sat_inc(cur.lines);
          nxt.longest    = utsc_pkg::max_count(cur.longest, cur.line_width);
          nxt.line_width = '0;
        end else if (data_byte == utsc_pkg::CHAR_TAB) begin
          nxt.line_width = utsc_pkg::sat_add(cur.line_width, tab_pad);
        end else if ((data_byte >= utsc_pkg::CHAR_SPACE) &&
                     (data_byte <= utsc_pkg::CHAR_TILDE)) begin
          nxt.line_width = utsc_pkg::sat_inc(cur.line_width);
        end
        if (cur.after_space && !utsc_pkg::is_ws(data_byte)) begin
          nxt.words = utsc_pkg::sat_inc(cur.words);
        end
        nxt.after_space = utsc_pkg::is_ws(data_byte);
      end else if ((data_byte >= utsc_pkg::LEAD2_MIN) && (data_byte <= utsc_pkg::LEAD2_MAX)) begin
        nxt.partial    = utsc_pkg::CP_BITS'(data_byte[4:0]);
        nxt.expect_cnt = 2'd1;
      end else if ((data_byte >= utsc_pkg::LEAD3_MIN) && (data_byte <= utsc_pkg::LEAD3_MAX)) begin
        nxt.partial    = utsc_pkg::CP_BITS'(data_byte[3:0]);
        nxt.expect_cnt = 2'd2;
      end else if ((data_byte >= utsc_pkg::LEAD4_MIN) && (data_byte <= utsc_pkg::LEAD4_MAX)) begin
        nxt.partial    = utsc_pkg::CP_BITS'(data_byte[2:0]);
        nxt.expect_cnt = 2'd3;
      end else begin
        bad_byte = 1'b1;
      end
    end
  end

endmodule

// ----- design/utf8_text_stats_counter.sv -----
// Top level: wc-style byte, character, word, line and longest-line counter for UTF-8 text.
//
// Input channel (in_valid / in_item / in_stall): one transaction per file byte
// (action data), one per end of file (action end, emits the file's counts and
// folds them into saturating totals) or one per totals request (action totals).
// Action code 3 is consumed and ignored.
// Output channel (out_valid / out_item / out_stall): one transaction per end or
// totals item; data bytes produce nothing.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
// always high; indexes 0..3 set the two double-width code point ranges (low 21
// bits of cfg_data), other indexes are dropped. Write only while idle.
// Path: a transaction is registered at the input; an end or totals result is then
// loaded into the output register, from which the receiver takes it.
// Throughput: one transaction per cycle while no result waits on a stalled output;
// the running file state updates through the byte decode step, which is the loop that sets it.
// When the receiver stalls, the result holds in the output register; data bytes
// keep flowing, and only an end or totals item behind a held result waits.
// Reset (rst, synchronous): clears all counts and totals, the error flag and
// both channels, and restores the default wide ranges.
module utf8_text_stats_counter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  utsc_pkg::in_item_t                   in_item,
  output logic                                 in_stall,
  output logic                                 out_valid,
  output utsc_pkg::out_item_t                  out_item,
  input  logic                                 out_stall,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [utsc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [utsc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  // input register
  logic                s1_valid;
  utsc_pkg::in_item_t  s1_item;

  // running state
  utsc_pkg::file_state_t file_st, file_next, step_next;
  utsc_pkg::wide_cfg_t   wide_cfg;
  logic                  error_seen, error_next, bad_byte;
  utsc_pkg::count_t      sum_lines, sum_words, sum_chars, sum_bytes, sum_longest;
  utsc_pkg::count_t      sum_lines_next, sum_words_next, sum_chars_next, sum_bytes_next;
  utsc_pkg::count_t      sum_longest_next, file_longest_final;

  utsc_pkg::out_item_t   out_next;
  logic                  has_result, out_free, s1_fire, load_out;
  logic                  is_data, is_end, is_totals;

  assign cfg_ready = 1'b1;

  assign is_data   = (s1_item.action == utsc_pkg::ACT_DATA);
  assign is_end    = (s1_item.action == utsc_pkg::ACT_END);
  assign is_totals = (s1_item.action == utsc_pkg::ACT_TOTALS);

  assign has_result = is_end || is_totals;
  assign out_free   = !out_valid || !out_stall;
  // only a result-bearing item waits for room in the output register
  assign s1_fire    = s1_valid && (!has_result || out_free);
  assign load_out   = s1_fire && has_result;
  assign in_stall   = s1_valid && !s1_fire;

  utsc_byte_step u_step (
    .cur       (file_st),
    .data_byte (s1_item.data_byte),
    .wide_cfg  (wide_cfg),
    .nxt       (step_next),
    .bad_byte  (bad_byte)
  );

  // the open line also counts toward the longest line at end of file
  assign file_longest_final = utsc_pkg::max_count(file_st.longest, file_st.line_width);

  always_comb begin
    file_next        = file_st;
    error_next       = error_seen;
    sum_lines_next   = sum_lines;
    sum_words_next   = sum_words;
    sum_chars_next   = sum_chars;
    sum_bytes_next   = sum_bytes;
    sum_longest_next = sum_longest;
    out_next         = '0;
    out_next.encoding_error = error_seen;

    case (s1_item.action)
      utsc_pkg::ACT_DATA: begin
        file_next  = step_next;
        error_next = error_seen || bad_byte;
      end
      utsc_pkg::ACT_END: begin
        out_next.line_total   = utsc_pkg::to_out(file_st.lines);
        out_next.word_total   = utsc_pkg::to_out(file_st.words);
        out_next.char_total   = utsc_pkg::to_out(file_st.chars);
        out_next.byte_total   = utsc_pkg::to_out(file_st.bytes);
        out_next.longest_line = utsc_pkg::to_out(file_longest_final);
        sum_lines_next   = utsc_pkg::sat_add(sum_lines, file_st.lines);
        sum_words_next   = utsc_pkg::sat_add(sum_words, file_st.words);
        sum_chars_next   = utsc_pkg::sat_add(sum_chars, file_st.chars);
        sum_bytes_next   = utsc_pkg::sat_add(sum_bytes, file_st.bytes);
        sum_longest_next = utsc_pkg::max_count(sum_longest, file_longest_final);
        file_next        = utsc_pkg::file_clear();
      end
      utsc_pkg::ACT_TOTALS: begin
        out_next.line_total     = utsc_pkg::to_out(sum_lines);
        out_next.word_total     = utsc_pkg::to_out(sum_words);
        out_next.char_total     = utsc_pkg::to_out(sum_chars);
        out_next.byte_total     = utsc_pkg::to_out(sum_bytes);
        out_next.longest_line   = utsc_pkg::to_out(sum_longest);
        out_next.is_grand_total = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item <= in_item;
    end
  end

  // running state and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      file_st     <= utsc_pkg::file_clear();
      error_seen  <= 1'b0;
      sum_lines   <= '0;
      sum_words   <= '0;
      sum_chars   <= '0;
      sum_bytes   <= '0;
      sum_longest <= '0;
    end else if (s1_fire) begin
      file_st     <= file_next;
      error_seen  <= error_next;
      sum_lines   <= sum_lines_next;
      sum_words   <= sum_words_next;
      sum_chars   <= sum_chars_next;
      sum_bytes   <= sum_bytes_next;
      sum_longest <= sum_longest_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wide_cfg.range1_low  <= utsc_pkg::WIDE1_LOW_RESET;
      wide_cfg.range1_high <= utsc_pkg::WIDE1_HIGH_RESET;
      wide_cfg.range2_low  <= utsc_pkg::WIDE2_LOW_RESET;
      wide_cfg.range2_high <= utsc_pkg::WIDE2_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        utsc_pkg::REG_WIDE1_LOW:  wide_cfg.range1_low  <= cfg_data[utsc_pkg::CP_BITS-1:0];
        utsc_pkg::REG_WIDE1_HIGH: wide_cfg.range1_high <= cfg_data[utsc_pkg::CP_BITS-1:0];
        utsc_pkg::REG_WIDE2_LOW:  wide_cfg.range2_low  <= cfg_data[utsc_pkg::CP_BITS-1:0];
        utsc_pkg::REG_WIDE2_HIGH: wide_cfg.range2_high <= cfg_data[utsc_pkg::CP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item <= out_next;
    end
  end

  // data bytes never wait on the output side
  a_data_never_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && is_data) |-> !in_stall)
    else $error("data byte held in input register");

  // an end item leaves a cleared file state behind
  a_end_clears_file: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && is_end) |=> (file_st.bytes == '0 && file_st.after_space &&
                             file_st.expect_cnt == 2'd0))
    else $error("file state not cleared after end of file");

  // a loaded result is presented next cycle with the matching report kind
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (out_valid && (out_item.is_grand_total == $past(is_totals))))
    else $error("result register not loaded");

  // byte and line totals never decrease
  a_totals_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (sum_bytes >= $past(sum_bytes) && sum_lines >= $past(sum_lines)))
    else $error("saturating total went down");

  // the error flag is sticky
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_seen |=> error_seen)
    else $error("encoding error flag cleared");

endmodule

// ----- bench/tb_utf8_text_stats_counter.sv -----
// Self-checking testbench for utf8_text_stats_counter: directed table, then random text files.
`timescale 1ns / 1ps

module tb_utf8_text_stats_counter;

  // Run shape
  localparam int CYCLE_LIMIT   = 500000;  // far above the slowest legal run
  localparam int ITEM_GOAL     = 950;     // random input transactions, spread over the phases
  localparam int PHASES        = 5;       // one wide-range setting per phase
  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off to back the block up
  localparam int SETTLE_CYCLES = 6;       // two-stage pipe plus margin

  // Action code the block must swallow without a report
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Config indexes that map to no register
  localparam logic [utsc_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED_LOW =
    utsc_pkg::CFG_INDEX_BITS'(4);
  localparam logic [utsc_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED_TOP = '1;

  localparam utsc_pkg::cp_t CP_LAST = utsc_pkg::CP_BITS'(21'h10FFFF);  // last code point

  typedef struct {
    utsc_pkg::in_item_t  item;
    bit                  typed;  // expected report written out by hand
    utsc_pkg::out_item_t want;
  } plan_row_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                in_valid;
  utsc_pkg::in_item_t                  in_item;
  logic                                in_stall;
  logic                                out_valid;
  utsc_pkg::out_item_t                 out_item;
  logic                                out_stall;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [utsc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [utsc_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  utf8_text_stats_counter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: the file being scanned, the running totals and the
  // double-width ranges as the bench believes the block holds them.
  // ---------------------------------------------------------------------------
  utsc_pkg::cp_t    wide1_lo, wide1_hi, wide2_lo, wide2_hi;
  utsc_pkg::count_t cur_bytes, cur_chars, cur_words, cur_lines, cur_width, cur_longest;
  logic             cur_blank;    // last character was whitespace (or start of file)
  utsc_pkg::cp_t    cur_cp;       // code point being assembled
  logic [1:0]       cur_pending;  // continuation bytes still owed
  logic             cur_error;    // sticky bad-encoding flag
  utsc_pkg::count_t sum_lines, sum_words, sum_chars, sum_bytes, sum_longest;

  utsc_pkg::out_item_t expected_reports[$];
  utsc_pkg::out_item_t head_report;

  // Bookkeeping
  int  failures        = 0;
  int  reports_checked = 0;
  int  items_sent      = 0;
  int  noise_sent      = 0;
  int  cfg_writes      = 0;
  int  cycles          = 0;
  bit  sender_calm;     // send the current file back to back
  bit  hold_request;    // main asks the receiver for a long hold-off

  // Counts stop at the all-ones value instead of wrapping
  function automatic utsc_pkg::count_t clamp_add(utsc_pkg::count_t a, utsc_pkg::count_t b);
    logic [utsc_pkg::COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, utsc_pkg::CNT_MAX}) ? utsc_pkg::CNT_MAX
                                             : s[utsc_pkg::COUNT_BITS-1:0];
  endfunction

  // Only space, tab, LF and CR split words
  function automatic bit is_blank(logic [7:0] b);
    return b == utsc_pkg::CHAR_SPACE || b == utsc_pkg::CHAR_TAB ||
           b == utsc_pkg::CHAR_LF || b == utsc_pkg::CHAR_CR;
  endfunction

  task automatic clear_file_counts();
    cur_bytes   = '0;
    cur_chars   = '0;
    cur_words   = '0;
    cur_lines   = '0;
    cur_width   = '0;
    cur_longest = '0;
    cur_blank   = 1'b1;
    cur_cp      = '0;
    cur_pending = '0;
  endtask

  task automatic reset_model();
    wide1_lo    = utsc_pkg::WIDE1_LOW_RESET;
    wide1_hi    = utsc_pkg::WIDE1_HIGH_RESET;
    wide2_lo    = utsc_pkg::WIDE2_LOW_RESET;
    wide2_hi    = utsc_pkg::WIDE2_HIGH_RESET;
    clear_file_counts();
    cur_error   = 1'b0;
    sum_lines   = '0;
    sum_words   = '0;
    sum_chars   = '0;
    sum_bytes   = '0;
    sum_longest = '0;
  endtask

  // Completed multibyte character: one column, two inside either wide range
  task automatic end_multibyte(utsc_pkg::cp_t cp);
    bit wide;
    wide = (cp >= wide1_lo && cp <= wide1_hi) || (cp >= wide2_lo && cp <= wide2_hi);
    cur_chars = clamp_add(cur_chars, 1);
    cur_width = clamp_add(cur_width, wide ? 2 : 1);
    if (cur_blank) cur_words = clamp_add(cur_words, 1);
    cur_blank = 1'b0;
  endtask

  // Byte seen outside any open sequence
  task automatic take_fresh_byte(logic [7:0] b);
    if (b <= utsc_pkg::ASCII_MAX) begin
      cur_chars = clamp_add(cur_chars, 1);
      if (b == utsc_pkg::CHAR_LF) begin
        cur_lines = clamp_add(cur_lines, 1);
        if (cur_width > cur_longest) cur_longest = cur_width;
        cur_width = '0;
      end
      if (b == utsc_pkg::CHAR_TAB) begin
        cur_width = clamp_add(cur_width,
                              utsc_pkg::count_t'(utsc_pkg::TAB_STOP) -
                              cur_width % utsc_pkg::count_t'(utsc_pkg::TAB_STOP));
      end else if (b >= utsc_pkg::CHAR_SPACE && b <= utsc_pkg::CHAR_TILDE) begin
        cur_width = clamp_add(cur_width, 1);
      end
      if (cur_blank && !is_blank(b)) cur_words = clamp_add(cur_words, 1);
      cur_blank = is_blank(b);
    end else if (b >= utsc_pkg::LEAD2_MIN && b <= utsc_pkg::LEAD2_MAX) begin
      cur_cp      = utsc_pkg::cp_t'(b[4:0]);
      cur_pending = 2'd1;
    end else if (b >= utsc_pkg::LEAD3_MIN && b <= utsc_pkg::LEAD3_MAX) begin
      cur_cp      = utsc_pkg::cp_t'(b[3:0]);
      cur_pending = 2'd2;
    end else if (b >= utsc_pkg::LEAD4_MIN && b <= utsc_pkg::LEAD4_MAX) begin
      cur_cp      = utsc_pkg::cp_t'(b[2:0]);
      cur_pending = 2'd3;
    end else begin
      // stray continuation or 0xF8..0xFF: counted as a byte only
      cur_error = 1'b1;
    end
  endtask

  // One accepted input transaction; returns the report it causes, if any
  task automatic predict_item(input utsc_pkg::in_item_t it, output bit has_report,
                              output utsc_pkg::out_item_t report);
    has_report = 1'b0;
    report     = '0;
    case (it.action)
      utsc_pkg::ACT_DATA: begin
        cur_bytes = clamp_add(cur_bytes, 1);
        if (cur_pending != 0 && it.data_byte >= utsc_pkg::CONT_MIN &&
            it.data_byte <= utsc_pkg::CONT_MAX) begin
          cur_cp      = {cur_cp[utsc_pkg::CP_BITS-7:0], it.data_byte[5:0]};
          cur_pending = cur_pending - 2'd1;
          if (cur_pending == 0) end_multibyte(cur_cp);
        end else begin
          // broken sequence: drop the partial character, then treat as fresh
          if (cur_pending != 0) begin
            cur_error   = 1'b1;
            cur_cp      = '0;
            cur_pending = '0;
          end
          take_fresh_byte(it.data_byte);
        end
      end
      utsc_pkg::ACT_END: begin
        // unterminated last line still counts toward the longest line; an open tail is dropped silently
        if (cur_width > cur_longest) cur_longest = cur_width;
        report.line_total     = cur_lines;
        report.word_total     = cur_words;
        report.char_total     = cur_chars;
        report.byte_total     = cur_bytes;
        report.longest_line   = cur_longest;
        report.encoding_error = cur_error;
        report.is_grand_total = 1'b0;
        sum_lines = clamp_add(sum_lines, cur_lines);
        sum_words = clamp_add(sum_words, cur_words);
        sum_chars = clamp_add(sum_chars, cur_chars);
        sum_bytes = clamp_add(sum_bytes, cur_bytes);
        if (cur_longest > sum_longest) sum_longest = cur_longest;
        clear_file_counts();
        has_report = 1'b1;
      end
      utsc_pkg::ACT_TOTALS: begin
        report.line_total     = sum_lines;
        report.word_total     = sum_words;
        report.char_total     = sum_chars;
        report.byte_total     = sum_bytes;
        report.longest_line   = sum_longest;
        report.encoding_error = cur_error;
        report.is_grand_total = 1'b1;
        has_report = 1'b1;
      end
      default: ;  // unused code: swallowed
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender side. Inputs change on the falling edge; a transaction completes on
  // the rising edge where in_valid is high and in_stall is low.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic sender_idle(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // valid is left high on a zero gap; the next call replaces the payload at
  // the very next falling edge, before any rising edge can see it again
  task automatic transfer(input utsc_pkg::in_item_t it, input bit typed,
                          input utsc_pkg::out_item_t typed_want);
    bit                  has_report;
    utsc_pkg::out_item_t report;
    @(negedge clk);
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk); while (in_stall);
    predict_item(it, has_report, report);
    if (has_report) expected_reports.push_back(typed ? typed_want : report);
    if (it.action == ACT_UNUSED) noise_sent++;
    else items_sent++;
    sender_idle(pick_gap());
  endtask

  task automatic send(logic [1:0] act, logic [7:0] b);
    utsc_pkg::in_item_t it;
    it.action    = act;
    it.data_byte = b;
    transfer(it, 1'b0, '0);
  endtask

  // Proper encoding of a code point; below 0x800 the 2-byte form is used,
  // which gives overlong forms for ASCII code points
  task automatic send_code_point(utsc_pkg::cp_t cp);
    if (cp < 21'h800) begin
      send(utsc_pkg::ACT_DATA, {3'b110, cp[10:6]});
      send(utsc_pkg::ACT_DATA, {2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      send(utsc_pkg::ACT_DATA, {4'b1110, cp[15:12]});
      send(utsc_pkg::ACT_DATA, {2'b10, cp[11:6]});
      send(utsc_pkg::ACT_DATA, {2'b10, cp[5:0]});
    end else begin
      send(utsc_pkg::ACT_DATA, {5'b11110, cp[20:18]});
      send(utsc_pkg::ACT_DATA, {2'b10, cp[17:12]});
      send(utsc_pkg::ACT_DATA, {2'b10, cp[11:6]});
      send(utsc_pkg::ACT_DATA, {2'b10, cp[5:0]});
    end
  endtask

  // Code points on and just off the edges of both wide ranges, or a random one from 0x80 up
  function automatic utsc_pkg::cp_t pick_code_point();
    case ($urandom_range(0, 9))
      0:       return wide1_lo;
      1:       return wide1_lo - 1'b1;
      2:       return wide1_hi;
      3:       return wide1_hi + 1'b1;
      4:       return wide2_lo;
      5:       return wide2_lo - 1'b1;
      6:       return wide2_hi;
      7:       return wide2_hi + 1'b1;
      default: return utsc_pkg::cp_t'($urandom_range(21'h80, 21'h10FFFF));
    endcase
  endfunction

  // Lead byte of a len-byte sequence with random payload, then count-1
  // continuation bytes; count < len leaves the sequence open
  task automatic send_raw_sequence(int len, int count);
    case (len)
      2: send(utsc_pkg::ACT_DATA,
              8'($urandom_range(utsc_pkg::LEAD2_MIN, utsc_pkg::LEAD2_MAX)));
      3: send(utsc_pkg::ACT_DATA,
              8'($urandom_range(utsc_pkg::LEAD3_MIN, utsc_pkg::LEAD3_MAX)));
      default: send(utsc_pkg::ACT_DATA,
                    8'($urandom_range(utsc_pkg::LEAD4_MIN, utsc_pkg::LEAD4_MAX)));
    endcase
    repeat (count - 1)
      send(utsc_pkg::ACT_DATA, 8'($urandom_range(utsc_pkg::CONT_MIN, utsc_pkg::CONT_MAX)));
  endtask

  // One file: mostly words, whitespace and good characters, with some noise
  // and broken sequences mixed in; closed by an end item, at times followed by totals
  task automatic send_file(int len);
    int start;
    int r;
    int ln;
    start       = items_sent;
    sender_calm = ($urandom_range(0, 9) == 0);
    while (items_sent - start < len) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        repeat ($urandom_range(1, 8))
          send(utsc_pkg::ACT_DATA, 8'($urandom_range(8'h21, utsc_pkg::CHAR_TILDE)));
      end else if (r < 52) begin
        case ($urandom_range(0, 5))
          0, 1:    send(utsc_pkg::ACT_DATA, utsc_pkg::CHAR_SPACE);
          2:       send(utsc_pkg::ACT_DATA, utsc_pkg::CHAR_TAB);
          3, 4:    send(utsc_pkg::ACT_DATA, utsc_pkg::CHAR_LF);
          default: send(utsc_pkg::ACT_DATA, utsc_pkg::CHAR_CR);
        endcase
      end else if (r < 64) begin
        send_code_point(pick_code_point());
      end else if (r < 74) begin
        ln = $urandom_range(2, 4);
        send_raw_sequence(ln, ln);
      end else if (r < 79) begin
        send(utsc_pkg::ACT_DATA, $urandom_range(0, 1) ? utsc_pkg::ASCII_MAX
                                                       : 8'($urandom_range(0, 8'h1F)));
      end else if (r < 85) begin
        // sequence cut short by a byte that is no continuation
        ln = $urandom_range(2, 4);
        send_raw_sequence(ln, $urandom_range(1, ln - 1));
        send(utsc_pkg::ACT_DATA,
             $urandom_range(0, 1) ? 8'($urandom_range(0, utsc_pkg::ASCII_MAX))
                                  : 8'($urandom_range(utsc_pkg::LEAD2_MIN, 8'hFF)));
      end else if (r < 90) begin
        send(utsc_pkg::ACT_DATA,
             $urandom_range(0, 1) ? 8'($urandom_range(utsc_pkg::CONT_MIN, utsc_pkg::CONT_MAX))
                                  : 8'($urandom_range(8'hF8, 8'hFF)));
      end else if (r < 93) begin
        send(ACT_UNUSED, 8'($urandom));
      end else begin
        send(utsc_pkg::ACT_DATA, 8'($urandom));
      end
    end
    // now and then the file ends inside a character
    if ($urandom_range(0, 6) == 0) begin
      ln = $urandom_range(2, 4);
      send_raw_sequence(ln, $urandom_range(1, ln - 1));
    end
    send(utsc_pkg::ACT_END, 8'($urandom));
    if ($urandom_range(0, 4) == 0) send(utsc_pkg::ACT_TOTALS, 8'($urandom));
    sender_calm = 1'b0;
  endtask

  // Sender waits until every report is out, then lets the pipe go quiet
  task automatic drain_reports();
    sender_idle(1);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Config port: junk above bit 20 must be ignored
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [utsc_pkg::CFG_INDEX_BITS-1:0] idx, utsc_pkg::cp_t value);
    logic [utsc_pkg::CFG_DATA_BITS-1:0] word;
    word                        = $urandom;
    word[utsc_pkg::CP_BITS-1:0] = value;
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = word;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      utsc_pkg::REG_WIDE1_LOW:  wide1_lo = word[utsc_pkg::CP_BITS-1:0];
      utsc_pkg::REG_WIDE1_HIGH: wide1_hi = word[utsc_pkg::CP_BITS-1:0];
      utsc_pkg::REG_WIDE2_LOW:  wide2_lo = word[utsc_pkg::CP_BITS-1:0];
      utsc_pkg::REG_WIDE2_HIGH: wide2_hi = word[utsc_pkg::CP_BITS-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_ranges(utsc_pkg::cp_t lo1, utsc_pkg::cp_t hi1,
                            utsc_pkg::cp_t lo2, utsc_pkg::cp_t hi2);
    write_reg(utsc_pkg::REG_WIDE1_LOW, lo1);
    write_reg(utsc_pkg::REG_WIDE1_HIGH, hi1);
    write_reg(utsc_pkg::REG_WIDE2_LOW, lo2);
    write_reg(utsc_pkg::REG_WIDE2_HIGH, hi2);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  plan_row_t plan[$];

  task automatic plan_add(logic [1:0] act, logic [7:0] b, bit typed,
                          utsc_pkg::out_item_t want);
    plan_row_t row;
    row.item.action    = act;
    row.item.data_byte = b;
    row.typed          = typed;
    row.want           = want;
    plan.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall runs, calm stretches, and on request one long
  // hold-off timed here so the sender keeps pushing meanwhile.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int run;
    bit level;
    int r;
    run   = 0;
    level = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
        run          = 0;
      end else begin
        if (run == 0) begin
          r = $urandom_range(0, 99);
          if (r < 5) begin
            level = 1'b0;
            run   = $urandom_range(50, 150);
          end else if (r < 65) begin
            level = 1'b0;
            run   = $urandom_range(1, 6);
          end else if (r < 95) begin
            level = 1'b1;
            run   = $urandom_range(1, 3);
          end else begin
            level = 1'b1;
            run   = $urandom_range(10, 40);
          end
        end
        out_stall = level;
        run--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every report taken by the receiver is matched against the
  // oldest expectation, field by field.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [utsc_pkg::OUT_BITS-1:0] want,
                             logic [utsc_pkg::OUT_BITS-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("report with nothing pending: %h", out_item);
        failures++;
      end else begin
        head_report = expected_reports.pop_front();
        check_field("line_total", head_report.line_total, out_item.line_total);
        check_field("word_total", head_report.word_total, out_item.word_total);
        check_field("char_total", head_report.char_total, out_item.char_total);
        check_field("byte_total", head_report.byte_total, out_item.byte_total);
        check_field("longest_line", head_report.longest_line, out_item.longest_line);
        check_field("encoding_error", head_report.encoding_error, out_item.encoding_error);
        check_field("is_grand_total", head_report.is_grand_total, out_item.is_grand_total);
        reports_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[utf8_text_stats_counter] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    utsc_pkg::out_item_t want;
    int                  random_base;
    int                  phase;
    bit                  pressured;
    utsc_pkg::cp_t       lo_a;
    utsc_pkg::cp_t       lo_b;

    rst          = 1'b1;
    in_valid     = 1'b0;
    in_item      = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    hold_request = 1'b0;
    sender_calm  = 1'b0;
    pressured    = 1'b0;
    reset_model();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Right after reset: an empty file and empty totals, known by eye
    want = '0;
    plan_add(utsc_pkg::ACT_END, 8'h00, 1'b1, want);
    want.is_grand_total = 1'b1;
    plan_add(utsc_pkg::ACT_TOTALS, 8'hFF, 1'b1, want);
    plan_add(ACT_UNUSED, 8'hA5, 1'b0, '0);
    // ASCII: letter, space, printable top, tab, CR, LF, NUL, DEL
    plan_add(utsc_pkg::ACT_DATA, 8'h41, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, utsc_pkg::CHAR_SPACE, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, utsc_pkg::CHAR_TILDE, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, utsc_pkg::CHAR_TAB, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, utsc_pkg::CHAR_CR, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, utsc_pkg::CHAR_LF, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, 8'h00, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, utsc_pkg::ASCII_MAX, 1'b0, '0);
    // 2-byte narrow, 3-byte in the first wide range, 4-byte narrow
    plan_add(utsc_pkg::ACT_DATA, 8'hC3, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, 8'hA9, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, 8'hE4, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, 8'hB8, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, 8'hAD, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, 8'hF0, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, 8'h9F, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, 8'h98, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, 8'h80, 1'b0, '0);
    plan_add(utsc_pkg::ACT_END, 8'h00, 1'b0, '0);
    // Lone bad lead byte: one byte, no char, error set
    plan_add(utsc_pkg::ACT_DATA, 8'hFF, 1'b0, '0);
    want = '0;
    want.byte_total     = 1;
    want.encoding_error = 1'b1;
    plan_add(utsc_pkg::ACT_END, 8'h00, 1'b1, want);
    // Broken sequence, then a file ending inside a character
    plan_add(utsc_pkg::ACT_DATA, 8'hE4, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, 8'h41, 1'b0, '0);
    plan_add(utsc_pkg::ACT_DATA, 8'hC3, 1'b0, '0);
    plan_add(utsc_pkg::ACT_END, 8'h00, 1'b0, '0);
    plan_add(utsc_pkg::ACT_TOTALS, 8'h00, 1'b0, '0);

    foreach (plan[i]) transfer(plan[i].item, plan[i].typed, plan[i].want);

    // Random files, one range setting per phase; config only with the pipe empty
    random_base = items_sent;
    for (phase = 0; phase < PHASES; phase++) begin
      drain_reports();
      case (phase)
        0: ;  // reset ranges
        1: set_ranges('0, CP_LAST, '0, CP_LAST);     // everything wide
        2: set_ranges(CP_LAST, '0, CP_LAST, '0);     // low above high: nothing wide
        3: begin
          lo_a = utsc_pkg::cp_t'($urandom_range(0, 21'h10FFFF));
          lo_b = utsc_pkg::cp_t'($urandom_range(0, 21'h10FFFF));
          set_ranges(lo_a, lo_a + utsc_pkg::cp_t'($urandom_range(0, 20000)),
                     lo_b, lo_b + utsc_pkg::cp_t'($urandom_range(0, 20000)));
        end
        default: begin
          // unmapped indexes must leave the ranges alone
          write_reg(REG_UNMAPPED_LOW, utsc_pkg::cp_t'($urandom));
          write_reg(REG_UNMAPPED_TOP, utsc_pkg::cp_t'($urandom));
          lo_b = utsc_pkg::cp_t'($urandom_range(21'h80, 21'h10FFFF));
          set_ranges(utsc_pkg::WIDE1_LOW_RESET, utsc_pkg::WIDE1_HIGH_RESET, lo_b, lo_b);
        end
      endcase
      while (items_sent - random_base < (phase + 1) * ITEM_GOAL / PHASES) begin
        if (phase == 1 && !pressured) begin
          // receiver holds off while short files keep coming, so reports
          // pile up and the block pushes back on its input
          hold_request = 1'b1;
          repeat (8) send_file($urandom_range(0, 3));
          drain_reports();
          pressured = 1'b1;
        end else begin
          send_file($urandom_range(0, 24));
        end
      end
    end

    drain_reports();

    $display("Covered %0d input transactions (%0d unused-code), %0d reports checked,",
             items_sent + noise_sent, noise_sent, reports_checked);
    $display("%0d config writes across %0d wide-range settings.", cfg_writes, PHASES);
    if (failures == 0) begin
      $display("[utf8_text_stats_counter] OK");
    end else begin
      $display("[utf8_text_stats_counter] ERROR");
    end
    $finish;
  end

endmodule
